FILE: rtl/id_set_table_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks in the identifier set table.
// ----------------------------------------------------------------------------
`ifndef ID_SET_TABLE_TOP_ASSERT_SVH
`define ID_SET_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ids_pkg.sv
// ----------------------------------------------------------------------------
// Identifier set table package
// Sizes, operation codes and the control bundle of the cell chain.
// ----------------------------------------------------------------------------
package ids_pkg;

    localparam int DEPTH   = 32;
    localparam int ENTRY_W = 32;
    localparam int FILL_W  = 6;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        logic               shift;
        logic               load;
        logic [ENTRY_W-1:0] data;
    } chain_ctl_t;

endpackage

FILE: rtl/ids_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying an operation and an identifier.
// ----------------------------------------------------------------------------
interface ids_req_if;

    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] ident;

    modport source (output valid, output operation, output ident, input ready);
    modport sink   (input valid, input operation, input ident, output ready);

endinterface

FILE: rtl/ids_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the lookup flag and the fill level.
// ----------------------------------------------------------------------------
interface ids_rsp_if;

    logic       valid;
    logic       ready;
    logic       present;
    logic [5:0] fill;

    modport source (output valid, output present, output fill, input ready);
    modport sink   (input valid, input present, input fill, output ready);

endinterface

FILE: rtl/ids_cell.sv
// ----------------------------------------------------------------------------
// Table cell
// Holds one stored identifier and passes it to its neighbor on each shift.
// ----------------------------------------------------------------------------
module ids_cell
(
    input  logic                        clk,
    input  logic                        shift,
    input  logic                        load,
    input  logic [ids_pkg::ENTRY_W-1:0] load_data,
    input  logic [ids_pkg::ENTRY_W-1:0] shift_in,
    output logic [ids_pkg::ENTRY_W-1:0] value
);

    logic [ids_pkg::ENTRY_W-1:0] value_reg;
    logic [ids_pkg::ENTRY_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (shift)
        begin
            value_next = load ? load_data : shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: rtl/ids_ctrl.sv
// ----------------------------------------------------------------------------
// Table sequencer
// Rotates the cell ring once per pass, compares the head entry and decides
// where the ring takes a new value.
// ----------------------------------------------------------------------------
`include "id_set_table_top_assert.svh"

module ids_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    ids_req_if.sink                     req,
    ids_rsp_if.source                   rsp,
    input  logic [ids_pkg::ENTRY_W-1:0] head,
    output ids_pkg::chain_ctl_t         chain
);

    localparam int IDX_W = ids_pkg::IDX_W;
    localparam int CNT_W = ids_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [IDX_W-1:0]             step_reg, step_next;
    logic                         pass2_reg, pass2_next;
    logic                         found_reg, found_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [IDX_W-1:0]             wrap_reg, wrap_next;
    logic                         rsp_valid_reg, rsp_valid_next;

    ids_pkg::op_t                 op_reg, op_next;
    logic [ids_pkg::ENTRY_W-1:0]  key_reg, key_next;
    logic [IDX_W-1:0]             hit_reg, hit_next;
    logic [ids_pkg::ENTRY_W-1:0]  last_reg, last_next;
    logic                         present_reg, present_next;
    logic [ids_pkg::FILL_W-1:0]   fill_reg, fill_next;

    logic                         step_last;
    logic                         is_live;
    logic                         is_full;
    logic                         match;
    logic [CNT_W-1:0]             last_idx;

    always_comb
    begin
        step_last = (step_reg == IDX_W'(ids_pkg::DEPTH - 1));
        is_live   = (CNT_W'(step_reg) < count_reg);
        is_full   = (count_reg == CNT_W'(ids_pkg::DEPTH));
        last_idx  = count_reg - CNT_W'(1);
        match     = !pass2_reg && is_live && (head == key_reg) && !found_reg;
    end

    always_comb
    begin
        chain.shift = (state_reg == ST_SCAN);
        chain.load  = 1'b0;
        chain.data  = key_reg;
        if (state_reg == ST_SCAN)
        begin
            if (op_reg == ids_pkg::OP_INSERT)
            begin
                chain.load = is_full ? (step_reg == wrap_reg)
                                     : (CNT_W'(step_reg) == count_reg);
            end
            else if (op_reg == ids_pkg::OP_REMOVE && pass2_reg)
            begin
                chain.load = (step_reg == hit_reg);
                chain.data = last_reg;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        pass2_next     = pass2_reg;
        found_next     = found_reg;
        count_next     = count_reg;
        wrap_next      = wrap_reg;
        rsp_valid_next = rsp_valid_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        last_next      = last_reg;
        present_next   = present_reg;
        fill_next      = fill_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = ids_pkg::op_t'(req.operation);
                    key_next   = req.ident;
                    found_next = 1'b0;
                    pass2_next = 1'b0;
                    step_next  = '0;
                    if (ids_pkg::op_t'(req.operation) == ids_pkg::OP_CLEAR)
                    begin
                        count_next = '0;
                        wrap_next  = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                step_next = step_last ? '0 : step_reg + IDX_W'(1);
                if (match)
                begin
                    found_next = 1'b1;
                    hit_next   = step_reg;
                end
                if (op_reg == ids_pkg::OP_REMOVE && !pass2_reg && count_reg != '0
                    && CNT_W'(step_reg) == last_idx)
                begin
                    last_next = head;
                end
                if (step_last)
                begin
                    if (op_reg == ids_pkg::OP_REMOVE && !pass2_reg && found_next)
                    begin
                        pass2_next = 1'b1;
                    end
                    else
                    begin
                        if (op_reg == ids_pkg::OP_INSERT)
                        begin
                            if (!is_full)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                wrap_next = (wrap_reg == IDX_W'(ids_pkg::DEPTH - 1))
                                            ? '0 : wrap_reg + IDX_W'(1);
                            end
                        end
                        else if (op_reg == ids_pkg::OP_REMOVE && pass2_reg)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    present_next   = found_reg;
                    fill_next      = ids_pkg::FILL_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            pass2_reg     <= 1'b0;
            found_reg     <= 1'b0;
            count_reg     <= '0;
            wrap_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pass2_reg     <= pass2_next;
            found_reg     <= found_next;
            count_reg     <= count_next;
            wrap_reg      <= wrap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        hit_reg     <= hit_next;
        last_reg    <= last_next;
        present_reg <= present_next;
        fill_reg    <= fill_next;
    end

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.present = present_reg;
    assign rsp.fill    = fill_reg;

    `IDS_ASSERT_SAME(a_count_range, 1'b1, count_reg <= CNT_W'(ids_pkg::DEPTH), "count above depth")
    `IDS_ASSERT_SAME(a_pass2_found, pass2_reg, found_reg, "second pass without a match")
    `IDS_ASSERT_NEXT(a_wrap_hold, state_reg == ST_SCAN && step_last && op_reg == ids_pkg::OP_INSERT && !is_full, $stable(wrap_reg), "wrap pointer moved on append")
    `IDS_ASSERT_NEXT(a_done_wait, state_reg == ST_DONE && rsp_valid_reg && !rsp.ready, state_reg == ST_DONE, "result dropped while output stalled")

endmodule

FILE: rtl/id_set_table_top.sv
// ----------------------------------------------------------------------------
// Identifier set table
// Set of up to 32 identifiers with ring overwrite when full, held in a
// rotating chain of cells and searched one entry per cycle.
// ----------------------------------------------------------------------------
//  Channel  Role  Payload
//  req      sink  operation, ident
//  rsp      src   present, fill
//
// A query or insert is accepted, rotates the ring once through every entry and
// then posts the response. A remove that finds its identifier rotates the ring
// twice. A clear skips the rotation. A new request is taken while an earlier
// response still waits.
// Reset clears the count and the wrap pointer; stored entries are not cleared.
// ----------------------------------------------------------------------------
module id_set_table_top
(
    input  logic      clk,
    input  logic      rst_n,
    ids_req_if.sink   req,
    ids_rsp_if.source rsp
);

    localparam int DEPTH = ids_pkg::DEPTH;

    logic [ids_pkg::ENTRY_W-1:0] cell_value [DEPTH];
    ids_pkg::chain_ctl_t         chain;

    ids_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .head  (cell_value[0]),
        .chain (chain)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == DEPTH - 1)
        begin : g_tail
            ids_cell u_cell
            (
                .clk       (clk),
                .shift     (chain.shift),
                .load      (chain.load),
                .load_data (chain.data),
                .shift_in  (cell_value[0]),
                .value     (cell_value[i])
            );
        end
        else
        begin : g_body
            ids_cell u_cell
            (
                .clk       (clk),
                .shift     (chain.shift),
                .load      (1'b0),
                .load_data (chain.data),
                .shift_in  (cell_value[i+1]),
                .value     (cell_value[i])
            );
        end
    end

endmodule

FILE: sim/id_set_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier set table testbench
// Drives query, insert, remove and clear requests with random gaps on both
// channels, keeps its own copy of the table to predict each response and
// compares every response with the oldest prediction.
// ----------------------------------------------------------------------------
module id_set_table_top_tb;

    import ids_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic              present;
        logic [FILL_W-1:0] fill;
    } lookup_t;

    logic clk;
    logic rst_n;

    ids_req_if req ();
    ids_rsp_if rsp ();

    id_set_table_top uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    logic [ENTRY_W-1:0] held_ids [DEPTH];
    int                 held_count;
    int                 ring_pos;
    lookup_t            lookup_q [$];
    int                 failures;
    int                 cycle_count;
    bit                 src_idle_on;
    bit                 sink_idle_on;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        failures++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    function automatic lookup_t apply_op(input op_t op, input logic [ENTRY_W-1:0] id);
        lookup_t res;
        int      hit;
        hit = -1;
        if (op != OP_CLEAR)
        begin
            for (int i = 0; i < held_count; i++)
            begin
                if (held_ids[i] == id)
                begin
                    hit = i;
                    break;
                end
            end
        end
        res.present = (hit >= 0);
        case (op)
            OP_INSERT:
            begin
                if (held_count < DEPTH)
                begin
                    held_ids[held_count] = id;
                    held_count++;
                end
                else
                begin
                    held_ids[ring_pos] = id;
                    ring_pos = (ring_pos + 1 >= DEPTH) ? 0 : ring_pos + 1;
                end
            end
            OP_REMOVE:
            begin
                if (hit >= 0)
                begin
                    held_ids[hit] = held_ids[held_count - 1];
                    held_count--;
                end
            end
            OP_CLEAR:
            begin
                held_count = 0;
                ring_pos = 0;
            end
            default:
            begin
            end
        endcase
        res.fill = FILL_W'(held_count);
        return res;
    endfunction

    // Entered and left at a falling edge.
    task automatic send_req(input op_t op, input logic [ENTRY_W-1:0] id);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        req.ident     <= id;
        do
            @(posedge clk);
        while (!req.ready);
        lookup_q.push_back(apply_op(op, id));
        @(negedge clk);
    endtask

    function automatic logic [ENTRY_W-1:0] pick_ident();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && held_count > 0)
        begin
            return held_ids[$urandom_range(0, held_count - 1)];
        end
        else if (r < 7)
        begin
            return ENTRY_W'($urandom_range(0, 15));
        end
        return $urandom();
    endfunction

    initial
    begin
        int      gap;
        lookup_t want;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = sink_idle_on ? $urandom_range(0, 9) : 0;
            if (gap != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            if (lookup_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response present=%0b fill=%0d",
                                          rsp.present, rsp.fill));
            end
            else
            begin
                want = lookup_q.pop_front();
                if (rsp.present !== want.present)
                begin
                    report_mismatch($sformatf("present: got %0b, expected %0b",
                                              rsp.present, want.present));
                end
                if (rsp.fill !== want.fill)
                begin
                    report_mismatch($sformatf("fill: got %0d, expected %0d",
                                              rsp.fill, want.fill));
                end
            end
            @(negedge clk);
        end
    end

    task automatic test_directed();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_req(OP_QUERY, 32'h0000_0000);
        send_req(OP_REMOVE, 32'h0000_0000);
        send_req(OP_INSERT, 32'h0000_0000);
        send_req(OP_INSERT, 32'hFFFF_FFFF);
        send_req(OP_QUERY, 32'hFFFF_FFFF);
        send_req(OP_QUERY, 32'h0000_0000);
        send_req(OP_INSERT, 32'h0000_0000);
        send_req(OP_INSERT, 32'hA5A5_5A5A);
        send_req(OP_REMOVE, 32'h0000_0000);
        send_req(OP_QUERY, 32'h0000_0000);
        send_req(OP_REMOVE, 32'h1234_5678);
        send_req(OP_QUERY, 32'hA5A5_5A5A);
        send_req(OP_REMOVE, 32'hFFFF_FFFF);
        send_req(OP_REMOVE, 32'h0000_0000);
        send_req(OP_QUERY, 32'h0000_0000);
        send_req(OP_CLEAR, 32'hFFFF_FFFF);
        send_req(OP_QUERY, 32'hA5A5_5A5A);
        send_req(OP_INSERT, 32'h8000_0001);
        send_req(OP_CLEAR, 32'h0000_0000);
        send_req(OP_CLEAR, 32'h7FFF_FFFE);
        send_req(OP_QUERY, 32'h8000_0001);
    endtask

    // Fill to capacity, overwrite more than a full turn of the ring, then shrink and refill
    // so that the ring pointer is picked up again where it was left.
    task automatic test_fill_wrap();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b1;
        send_req(OP_CLEAR, $urandom());
        for (int i = 0; i < DEPTH; i++)
        begin
            send_req(OP_INSERT, $urandom());
        end
        for (int i = 0; i < DEPTH + 5; i++)
        begin
            send_req(OP_INSERT, ENTRY_W'(i));
        end
        send_req(OP_QUERY, held_ids[0]);
        send_req(OP_REMOVE, held_ids[3]);
        send_req(OP_REMOVE, held_ids[held_count - 1]);
        send_req(OP_INSERT, 32'hDEAD_0001);
        send_req(OP_INSERT, 32'hDEAD_0002);
        for (int i = 0; i < 4; i++)
        begin
            send_req(OP_INSERT, 32'hBEEF_0000 + ENTRY_W'(i));
        end
        send_req(OP_QUERY, 32'hBEEF_0003);
    endtask

    task automatic run_mix(input int count, input int w_query, input int w_insert,
                           input int w_remove, input int w_clear);
        int   r;
        op_t  op;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, w_query + w_insert + w_remove + w_clear - 1);
            if (r < w_query)
            begin
                op = OP_QUERY;
            end
            else if (r < w_query + w_insert)
            begin
                op = OP_INSERT;
            end
            else if (r < w_query + w_insert + w_remove)
            begin
                op = OP_REMOVE;
            end
            else
            begin
                op = OP_CLEAR;
            end
            send_req(op, pick_ident());
        end
    endtask

    task automatic test_random();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        run_mix(300, 20, 60, 18, 2);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        run_mix(300, 25, 40, 34, 1);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b0;
        run_mix(300, 15, 70, 14, 1);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b1;
        run_mix(300, 25, 25, 45, 5);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        run_mix(300, 20, 50, 29, 1);
        run_mix(300, 30, 35, 30, 5);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.operation = OP_QUERY;
        req.ident     = '0;
        failures      = 0;
        cycle_count   = 0;
        held_count    = 0;
        ring_pos      = 0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_fill_wrap();
        test_random();

        req.valid <= 1'b0;
        while (lookup_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ids_pkg.sv
rtl/ids_req_if.sv
rtl/ids_rsp_if.sv
rtl/ids_cell.sv
rtl/ids_ctrl.sv
rtl/id_set_table_top.sv
sim/id_set_table_top_tb.sv
